FILE: hw/rtl/ctp_pkg.sv
`default_nettype none

package ctp_pkg;

   // width of the angle accumulator: 32 fraction bits, sign and guard bits
   localparam int ACC_W = 36;

   // largest iteration count the arctangent table supports
   localparam int MAX_ITER = 16;

   typedef logic signed [ACC_W-1:0] acc_type;

   // pi/2 at 2^-32
   localparam acc_type HALF_PI_Q32 = 36'sd6746518852;

   // magnitude gain 0.60735 at 2^-32
   localparam logic [31:0] GAIN_Q32 = 32'd2608548387;

   // atan(2^-j) at 2^-32, rounded to nearest
   localparam logic [31:0] ATAN_TABLE [MAX_ITER] = '{
      32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
      32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
      32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
      32'd1048576,    32'd524288,     32'd262144,     32'd131072
   };

endpackage

`default_nettype wire

FILE: hw/rtl/cordic_cartesian_to_polar_unit.sv
`default_nettype none

// Cartesian to polar conversion by CORDIC vectoring. Each transaction on the
// req side carries one point (x, y) in signed Q2.30; the rsp side returns its
// radius (unsigned Q2.30, times the CORDIC gain correction 0.60735, saturated
// at all ones) and its angle (signed Q3.29 radians). Every input gives exactly
// one result, in order. The pipeline takes one point per clock while
// rsp_tready is held high and has ITERATIONS + 4 register stages: a
// quarter-turn pre-rotation stage, one stage per micro-rotation, two stages
// for the gain multiply (split into two 32x32 partial products, then summed)
// and the output register. Stages with no valid data collapse under
// backpressure, so input keeps flowing while the output register holds a
// result that has not been taken, until every stage is full.
module cordic_cartesian_to_polar_unit #(
   parameter int ITERATIONS = 16,   // micro-rotations, 1 to 16
   parameter int DATA_WIDTH = 32    // internal x/y precision, 16 to 48
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,    // [31:0] x_in, [63:32] y_in

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata     // [31:0] radius, [63:32] angle
);

   // x/y fraction bits and working width with guard bits (gain ~1.65 on
   // a magnitude up to 2*sqrt(2), plus sign)
   localparam int FRAC = DATA_WIDTH - 2;
   localparam int W    = DATA_WIDTH + 4;

   // input conversion from Q2.30 to FRAC fraction bits
   localparam int SH_L = (FRAC >= 30) ? FRAC - 30 : 0;
   localparam int SH_R = (FRAC < 30) ? 30 - FRAC : 0;

   // final conversion of the gain product to Q2.30
   localparam int RS = (FRAC > 30) ? FRAC - 30 : 0;
   localparam int LS = (FRAC < 30) ? 30 - FRAC : 0;
   localparam logic [64:0] RND_HALF = (RS > 0) ? (65'd1 << (RS - 1)) : 65'd0;

   // stage map: 0 pre-rotation, 1..ITERATIONS micro-rotations, then
   // multiply, sum and output
   localparam int ST_MUL = ITERATIONS + 1;
   localparam int ST_SUM = ITERATIONS + 2;
   localparam int NS     = ITERATIONS + 4;

   // per-stage valid bits and load enables
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] go;

   // x, y and angle registers of the pre-rotation and micro-rotation stages
   logic signed [W-1:0]   cx_ff  [ITERATIONS+1];
   logic signed [W-1:0]   cy_ff  [ITERATIONS+1];
   ctp_pkg::acc_type      acc_ff [ITERATIONS+1];

   // multiply stage
   logic [63:0] lo_g_ff, lo_g_in;
   logic [63:0] hi_g_ff, hi_g_in;
   logic [31:0] ang_m_ff, ang_m_in;

   // sum stage
   logic [63:0] prod_ff, prod_in;
   logic [31:0] ang_s_ff;

   // output stage
   logic [31:0] radius_ff, radius_in;
   logic [31:0] angle_ff;

   // ---------------------------------------------------------------------
   // flow control: a stage loads when it is empty or its successor loads
   // ---------------------------------------------------------------------
   always_comb begin
      go[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   always_comb begin
      valid_in[0] = go[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = go[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = go[0];

   // ---------------------------------------------------------------------
   // pre-rotation by a quarter turn: +pi/2 when y > 0, else -pi/2
   // ---------------------------------------------------------------------
   logic signed [31:0]   x_s, y_s;
   logic signed [32:0]   px, py;
   logic signed [W+32:0] px_ext, py_ext;
   logic signed [W-1:0]  px_in, py_in;
   ctp_pkg::acc_type     pacc_in;

   always_comb begin
      x_s = signed'(req_tdata[31:0]);
      y_s = signed'(req_tdata[63:32]);
      if (y_s > 32'sd0) begin
         px      = 33'(y_s);
         py      = -33'(x_s);
         pacc_in = ctp_pkg::HALF_PI_Q32;
      end else begin
         px      = -33'(y_s);
         py      = 33'(x_s);
         pacc_in = -ctp_pkg::HALF_PI_Q32;
      end
      // widen first so that a narrow working width sees the shifted value
      px_ext = (W + 33)'(px);
      py_ext = (W + 33)'(py);
      px_in  = W'((px_ext >>> SH_R) <<< SH_L);
      py_in  = W'((py_ext >>> SH_R) <<< SH_L);
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         cx_ff[0]  <= px_in;
         cy_ff[0]  <= py_in;
         acc_ff[0] <= pacc_in;
      end
   end

   // ---------------------------------------------------------------------
   // micro-rotations: one stage each, steering y toward zero
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
      logic signed [W-1:0] xs, ys;
      logic signed [W-1:0] rx_in, ry_in;
      ctp_pkg::acc_type    ra_in;
      ctp_pkg::acc_type    step;

      always_comb begin
         xs   = cx_ff[i] >>> i;
         ys   = cy_ff[i] >>> i;
         step = ctp_pkg::ACC_W'(ctp_pkg::ATAN_TABLE[i]);
         if (cy_ff[i] > 0) begin
            rx_in = cx_ff[i] + ys;
            ry_in = cy_ff[i] - xs;
            ra_in = acc_ff[i] + step;
         end else begin
            rx_in = cx_ff[i] - ys;
            ry_in = cy_ff[i] + xs;
            ra_in = acc_ff[i] - step;
         end
      end

      always_ff @(posedge clock) begin
         if (go[i+1]) begin
            cx_ff[i+1]  <= rx_in;
            cy_ff[i+1]  <= ry_in;
            acc_ff[i+1] <= ra_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // gain multiply as two 32x32 partial products; angle rounding to Q3.29
   // ---------------------------------------------------------------------
   logic [63:0]      ux;
   ctp_pkg::acc_type ang_rnd;

   always_comb begin
      // a negative x would clamp to zero radius
      ux       = (cx_ff[ITERATIONS] > 0) ? 64'(unsigned'(cx_ff[ITERATIONS])) : 64'd0;
      lo_g_in  = 64'(ux[31:0]) * 64'(ctp_pkg::GAIN_Q32);
      hi_g_in  = 64'(ux[63:32]) * 64'(ctp_pkg::GAIN_Q32);
      ang_rnd  = (acc_ff[ITERATIONS] + ctp_pkg::ACC_W'(4)) >>> 3;
      ang_m_in = ang_rnd[31:0];
   end

   always_ff @(posedge clock) begin
      if (go[ST_MUL]) begin
         lo_g_ff  <= lo_g_in;
         hi_g_ff  <= hi_g_in;
         ang_m_ff <= ang_m_in;
      end
   end

   // ---------------------------------------------------------------------
   // partial product sum, low half rounded at 2^-32
   // ---------------------------------------------------------------------
   logic [64:0] lo_rnd;

   always_comb begin
      lo_rnd  = 65'(lo_g_ff) + 65'h0_8000_0000;
      prod_in = hi_g_ff + 64'(lo_rnd[64:32]);
   end

   always_ff @(posedge clock) begin
      if (go[ST_SUM]) begin
         prod_ff  <= prod_in;
         ang_s_ff <= ang_m_ff;
      end
   end

   // ---------------------------------------------------------------------
   // conversion to Q2.30 with round to nearest and saturation
   // ---------------------------------------------------------------------
   logic [64:0] conv;

   always_comb begin
      conv      = ((65'(prod_ff) + RND_HALF) >> RS) << LS;
      radius_in = (conv[64:32] != 33'd0) ? 32'hFFFF_FFFF : conv[31:0];
   end

   always_ff @(posedge clock) begin
      if (go[NS-1]) begin
         radius_ff <= radius_in;
         angle_ff  <= ang_s_ff;
      end
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {angle_ff, radius_ff};

`ifndef SYNTHESIS
   // an accepted transaction always lands in the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted transaction not captured by pre-rotation stage");

   // with every stage full and the output stalled, input must be held off
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline is full and stalled");

   // pre-rotation leaves x non-negative and the rotations keep it so
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ITERATIONS] |-> !cx_ff[ITERATIONS][W-1])
      else $error("negative x after micro-rotations");

   // total angle stays inside pi/2 plus the arctangent sum, far from wrapping
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((signed'(angle_ff) < 32'sd1800000000)
                      && (signed'(angle_ff) > -32'sd1800000000)))
      else $error("angle out of range");
`endif

endmodule

`default_nettype wire

FILE: bench/cordic_cartesian_to_polar_unit_tb.sv
`default_nettype none

module cordic_cartesian_to_polar_unit_tb;

   // pipeline depth with the default 16 micro-rotations
   localparam int MICRO_ROTATIONS = 16;
   localparam int PIPE_LATENCY    = MICRO_ROTATIONS + 4;

   // random part of the stimulus, and the stretch in it where neither side idles
   localparam int RANDOM_POINTS = 1630;
   localparam int STEADY_FIRST  = 700;
   localparam int STEADY_LAST   = 1000;

   // hang guard, far above a slow but correct run
   localparam int CYCLE_LIMIT = 200000;

   // per-cent chance of an idle cycle on either side
   localparam int IDLE_PERCENT = 26;

   // quarter turn at 2^-32
   localparam longint QUARTER_TURN_Q32 = 64'sd6746518852;

   // 0.60735 at 2^-32
   localparam longint unsigned RADIUS_GAIN_Q32 = 64'd2608548387;

   // origin: -pi/2 minus every arctangent step, then taken to Q3.29
   localparam logic [31:0] ORIGIN_ANGLE = -32'sd1779218350;

   localparam logic [31:0] X_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] X_MIN = 32'h8000_0000;
   localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] radius;
      logic [31:0] angle;
   } polar_type;

   // one directed point; known marks an expected result written in by hand
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      bit          known;
      polar_type   hand;
   } point_row_type;

   localparam int DIRECTED_POINTS = 22;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // [31:0] x_in, [63:32] y_in

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] radius, [63:32] angle

   // atan(2^-j) at 2^-32, rounded to nearest
   longint arctan_step [16] = '{
      64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
      64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
      64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
      64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072
   };

   // extremes, axes, the origin, zero y on both sides, diagonals, tiny values
   point_row_type directed_table [DIRECTED_POINTS] = '{
      '{32'h0, 32'h0, 1'b1, '{32'h0, ORIGIN_ANGLE}},
      '{X_MAX, 32'h0, 1'b0, '0},
      '{X_MIN, 32'h0, 1'b0, '0},
      '{32'h0, X_MAX, 1'b0, '0},
      '{32'h0, X_MIN, 1'b0, '0},
      '{X_MAX, X_MAX, 1'b0, '0},
      '{X_MIN, X_MIN, 1'b0, '0},
      '{X_MAX, X_MIN, 1'b0, '0},
      '{X_MIN, X_MAX, 1'b0, '0},
      '{32'h1, 32'h0, 1'b0, '0},
      '{32'h0, 32'h1, 1'b0, '0},
      '{MINUS_ONE, 32'h0, 1'b0, '0},
      '{32'h0, MINUS_ONE, 1'b0, '0},
      '{32'h1, 32'h1, 1'b0, '0},
      '{MINUS_ONE, MINUS_ONE, 1'b0, '0},
      '{32'h4000_0000, 32'h0, 1'b0, '0},
      '{32'hC000_0000, 32'h0, 1'b0, '0},
      '{32'h4000_0000, 32'h4000_0000, 1'b0, '0},
      '{32'h0, 32'h4000_0000, 1'b0, '0},
      '{X_MIN, 32'h1, 1'b0, '0},
      '{X_MIN, MINUS_ONE, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
   };

   polar_type pending_results [$];   // expected results, oldest first
   polar_type oldest_result;
   bit     steady = 1'b0;         // no idling on either side while set
   int     mismatches = 0;
   int     points_sent = 0;
   int     results_checked = 0;
   int     cycle_count = 0;

   cordic_cartesian_to_polar_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bit-exact vectoring: quarter-turn pre-rotation, 16 micro-rotations,
   // rounded gain multiply and rounded Q3.29 angle
   function automatic polar_type predict_polar(input logic [31:0] x, input logic [31:0] y);
      longint          xw, yw, cx, cy, xs, ys, phase;
      longint unsigned mag, hi, lo, prod;
      polar_type       p;
      xw = longint'($signed(x));
      yw = longint'($signed(y));
      // y strictly positive turns by +pi/2, zero or negative y by -pi/2
      if (yw > 0) begin
         cx    = yw;
         cy    = -xw;
         phase = QUARTER_TURN_Q32;
      end else begin
         cx    = -yw;
         cy    = xw;
         phase = -QUARTER_TURN_Q32;
      end
      for (int j = 0; j < MICRO_ROTATIONS; j++) begin
         xs = cx >>> j;
         ys = cy >>> j;
         if (cy > 0) begin
            cx    = cx + ys;
            cy    = cy - xs;
            phase = phase + arctan_step[j];
         end else begin
            cx    = cx - ys;
            cy    = cy + xs;
            phase = phase - arctan_step[j];
         end
      end
      // negative x' would clamp to zero radius
      mag  = (cx > 0) ? longint'(cx) : 64'd0;
      hi   = mag >> 32;
      lo   = mag & 64'hFFFF_FFFF;
      prod = hi * RADIUS_GAIN_Q32 + ((lo * RADIUS_GAIN_Q32 + 64'h8000_0000) >> 32);
      p.radius = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      phase    = (phase + 4) >>> 3;
      p.angle  = phase[31:0];
      return p;
   endfunction

   // one random coordinate, mixing full range, scaled, zero and edge values
   function automatic logic [31:0] random_coord(input int unsigned mode);
      logic [31:0] v;
      v = $urandom;
      case (mode)
         0: v = $urandom;
         1: v = $signed(v) >>> $urandom_range(0, 31);
         2: v = '0;
         default: begin
            case ($urandom_range(0, 4))
               0: v = X_MAX;
               1: v = X_MIN;
               2: v = MINUS_ONE;
               3: v = 32'h1;
               default: v = '0;
            endcase
         end
      endcase
      return v;
   endfunction

   // one point onto the req side; the expectation is queued once it is taken
   task automatic send_point(input logic [31:0] x, input logic [31:0] y, input polar_type want);
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(want);
      points_sent++;
      // random gaps after a transaction, unless in the steady stretch
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // result side backpressure
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // compare every result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: radius %h angle %h", rsp_tdata[31:0], rsp_tdata[63:32]);
            mismatches++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tdata[31:0] !== oldest_result.radius) begin
               $error("radius mismatch: expected %h, actual %h",
                      oldest_result.radius, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[63:32] !== oldest_result.angle) begin
               $error("angle mismatch: expected %h, actual %h",
                      oldest_result.angle, rsp_tdata[63:32]);
               mismatches++;
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [31:0] x, y;
      int unsigned kind;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: hand-written result where obvious, otherwise predicted
      for (int i = 0; i < DIRECTED_POINTS; i++) begin
         send_point(directed_table[i].x, directed_table[i].y,
                    directed_table[i].known ? directed_table[i].hand
                                            : predict_polar(directed_table[i].x,
                                                            directed_table[i].y));
      end

      // random points, with a long stretch of back-to-back traffic
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         steady = (i >= STEADY_FIRST) && (i < STEADY_LAST);
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            x = $urandom;
            y = $urandom;
         end else if (kind == 5) begin
            x = random_coord(1);
            y = random_coord(1);
         end else if (kind == 6) begin
            // a point on one axis
            x = random_coord($urandom_range(0, 1));
            y = '0;
            if ($urandom_range(0, 1)) begin
               y = x;
               x = '0;
            end
         end else if (kind == 7) begin
            x = random_coord(3);
            y = random_coord($urandom_range(0, 3));
         end else begin
            // diagonals with independent signs
            x = random_coord(1);
            y = $urandom_range(0, 1) ? x : -x;
         end
         send_point(x, y, predict_polar(x, y));
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then watch a while longer for stray results
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("covered %0d points (%0d from the directed table): extremes, axes, origin,",
               points_sent, DIRECTED_POINTS);
      $display("diagonals and full-range random data; %0d results compared, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/ctp_pkg.sv
hw/rtl/cordic_cartesian_to_polar_unit.sv
bench/cordic_cartesian_to_polar_unit_tb.sv
